// ----- sv/ngcr_pkg.sv -----
`timescale 1ns / 1ps

package ngcr_pkg;

	localparam int CURVE_ENTRIES = 1025;
	localparam int CURVE_AW      = 11;
	localparam int LEVEL_W       = 15;
	localparam int FRAC_W        = 5;
	localparam int NUM_CHAN      = 4;

	// input command codes, carried on tuser
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SHADE = 1'b1;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_AMPLITUDE   = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
	localparam logic [1:0] REG_COLOR_START = 2'd2;
	localparam logic [1:0] REG_COLOR_END   = 2'd3;

	localparam logic signed [31:0] AMPLITUDE_RST   = 32'sd32768;
	localparam logic               SIGNED_MODE_RST = 1'b0;
	localparam logic [31:0]        COLOR_START_RST = 32'hff00_0000;
	localparam logic [31:0]        COLOR_END_RST   = 32'hffff_ffff;

	localparam logic signed [31:0] LEVEL_OFFSET = 32'sh0000_4000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 15'h7fff;
	localparam logic [15:0]        WEIGHT_FULL  = 16'h8000;
	localparam logic [14:0]        WEIGHT_MAX   = 15'h7fff;

	typedef struct packed {
		logic signed [31:0] amplitude;
		logic               signed_mode;
		logic [31:0]        color_start;
		logic [31:0]        color_end;
	} cfg_t;

	typedef struct packed {
		logic                cmd;
		logic [CURVE_AW-1:0] idx;
		logic [15:0]         value;
		logic [LEVEL_W-1:0]  level;
	} scale_item_t;

	typedef struct packed {
		logic [14:0] wa;
		logic [14:0] wb;
	} weights_t;

	// channel byte of an ARGB word widened to 15 bits: (c * 257) >> 1
	function automatic logic [14:0] chan_expand(input logic [31:0] color, input int lane);
		logic [7:0] c;
		begin
			unique case (lane)
				0:       c = color[23:16];
				1:       c = color[15:8];
				2:       c = color[7:0];
				default: c = color[31:24];
			endcase
			chan_expand = {c, c[7:1]};
		end
	endfunction

endpackage

// ----- sv/ngcr_regs.sv -----
`timescale 1ns / 1ps

module ngcr_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ngcr_pkg::cfg_t    cfg
);
	import ngcr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude   <= AMPLITUDE_RST;
			cfg_q.signed_mode <= SIGNED_MODE_RST;
			cfg_q.color_start <= COLOR_START_RST;
			cfg_q.color_end   <= COLOR_END_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_AMPLITUDE:   cfg_q.amplitude   <= $signed(pwdata);
				REG_SIGNED_MODE: cfg_q.signed_mode <= pwdata[0];
				REG_COLOR_START: cfg_q.color_start <= pwdata;
				REG_COLOR_END:   cfg_q.color_end   <= pwdata;
				default:         cfg_q.color_end   <= cfg_q.color_end;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_AMPLITUDE:   prdata = cfg_q.amplitude;
			REG_SIGNED_MODE: prdata = {31'd0, cfg_q.signed_mode};
			REG_COLOR_START: prdata = cfg_q.color_start;
			REG_COLOR_END:   prdata = cfg_q.color_end;
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/ngcr_scale.sv -----
`timescale 1ns / 1ps

module ngcr_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ngcr_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_cmd,
	input  logic [10:0]           in_idx,
	input  logic [15:0]           in_value,
	input  logic signed [31:0]    in_noise,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ngcr_pkg::scale_item_t out_item
);
	import ngcr_pkg::*;

	logic                valid_s1, valid_s2;
	logic                ready_s1, ready_s2;
	logic                cmd_s1;
	logic [CURVE_AW-1:0] idx_s1;
	logic [15:0]         value_s1;
	logic signed [63:0]  prod_s1;
	logic signed [63:0]  prod_d;
	logic signed [31:0]  scaled;
	logic signed [31:0]  biased;
	logic [LEVEL_W-1:0]  level_d;
	scale_item_t         item_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign prod_d = 64'(in_noise) * 64'(cfg.amplitude);

	// arithmetic shift by 16, wrapped to 32 bits
	assign scaled = $signed(prod_s1[47:16]);
	assign biased = cfg.signed_mode ? scaled : scaled + LEVEL_OFFSET;

	always_comb begin
		priority if (biased[31])
			level_d = '0;
		else if (biased > $signed({17'd0, LEVEL_MAX}))
			level_d = LEVEL_MAX;
		else
			level_d = biased[LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			cmd_s1   <= in_cmd;
			idx_s1   <= in_idx;
			value_s1 <= in_value;
			prod_s1  <= prod_d;
		end
		if (ready_s2 && valid_s1) begin
			item_s2.cmd   <= cmd_s1;
			item_s2.idx   <= idx_s1;
			item_s2.value <= value_s1;
			item_s2.level <= level_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ----- sv/ngcr_curve.sv -----
`timescale 1ns / 1ps

module ngcr_curve (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ngcr_pkg::scale_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ngcr_pkg::weights_t    out_weights
);
	import ngcr_pkg::*;

	logic [15:0] curve_mem [CURVE_ENTRIES];

	logic                valid_s3, valid_s4;
	logic                ready_s3, ready_s4;
	logic [CURVE_AW-1:0] rd_a, rd_b;
	logic [15:0]         g0_s3, g1_s3;
	logic [FRAC_W-1:0]   frac_s3;
	logic signed [16:0]  diff;
	logic signed [22:0]  slope;
	logic signed [17:0]  fade_w;
	logic [14:0]         half;
	weights_t            weights_d, weights_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	assign rd_a = {1'b0, in_item.level[LEVEL_W-1:FRAC_W]};
	assign rd_b = rd_a + 1'b1;

	// loads write and shades read in this one stage, so order is kept
	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			if (in_item.cmd == CMD_LOAD && in_item.idx < CURVE_AW'(CURVE_ENTRIES))
				curve_mem[in_item.idx] <= in_item.value;
			g0_s3   <= curve_mem[rd_a];
			g1_s3   <= curve_mem[rd_b];
			frac_s3 <= in_item.level[FRAC_W-1:0];
		end
	end

	assign diff   = $signed({1'b0, g1_s3}) - $signed({1'b0, g0_s3});
	assign slope  = 23'(diff) * 23'($signed({1'b0, frac_s3}));
	assign fade_w = $signed({2'b00, g0_s3}) + 18'(slope >>> FRAC_W);
	// fade stays between g0 and g1, so 16 bits hold it
	assign half   = fade_w[15:1];

	always_comb begin
		weights_d.wb = half;
		if (half == '0)
			weights_d.wa = WEIGHT_MAX;
		else
			weights_d.wa = 15'(WEIGHT_FULL - {1'b0, half});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3)
				valid_s3 <= in_valid && (in_item.cmd == CMD_SHADE);
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3)
			weights_s4 <= weights_d;
	end

	assign out_valid   = valid_s4;
	assign out_weights = weights_s4;

endmodule

// ----- sv/ngcr_blend.sv -----
`timescale 1ns / 1ps

module ngcr_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  ngcr_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  ngcr_pkg::weights_t in_weights,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        out_chan [4]
);
	import ngcr_pkg::*;

	logic        valid_s5, valid_s6;
	logic        ready_s5, ready_s6;
	logic [29:0] pa_s5 [NUM_CHAN];
	logic [29:0] pb_s5 [NUM_CHAN];
	logic [15:0] chan_s6 [NUM_CHAN];

	assign ready_s6 = !valid_s6 || out_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign in_ready = ready_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s5)
				valid_s5 <= in_valid;
			if (ready_s6)
				valid_s6 <= valid_s5;
		end
	end

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		logic [14:0] ca, cb;
		logic [14:0] sum;

		assign ca  = chan_expand(cfg.color_start, c);
		assign cb  = chan_expand(cfg.color_end, c);
		assign sum = 15'(pa_s5[c][29:16]) + 15'(pb_s5[c][29:16]);

		always_ff @(posedge clk) begin
			if (ready_s5 && in_valid) begin
				pa_s5[c] <= ca * in_weights.wa;
				pb_s5[c] <= cb * in_weights.wb;
			end
			if (ready_s6 && valid_s5)
				chan_s6[c] <= {sum, 1'b0};
		end

		assign out_chan[c] = chan_s6[c];
	end

	assign out_valid = valid_s6;

endmodule

// ----- sv/noise_gamma_color_ramp_unit.sv -----
`timescale 1ns / 1ps
// An accepted shade transaction passes registered stages s1 to s6 (scale, curve, blend) before m_axis_tvalid.
// Throughput: one transaction per cycle, loads and shades mixed freely;
// a load gives no output, a shade gives one; each stage stalls on its own.
// The 32x32 amplitude multiply and the dual-read curve RAM never hold the flow; only back-pressure does.
// Reset (arst_n, async): pipeline valids cleared, registers to defaults;
// the gamma curve RAM is not cleared and must be loaded before it is read.
module noise_gamma_color_ramp_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // curve_index[10:0], curve_value[26:11], noise_sum[58:27]
	input  logic        s_axis_tuser,  // command[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // chan_red[15:0], chan_green[31:16], chan_blue[47:32], chan_alpha[63:48]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ngcr_pkg::*;

	cfg_t        cfg;
	logic        sc_valid, sc_ready;
	scale_item_t sc_item;
	logic        wt_valid, wt_ready;
	weights_t    wt;
	logic [15:0] chan [NUM_CHAN];

	ngcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ngcr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_idx    (s_axis_tdata[10:0]),
		.in_value  (s_axis_tdata[26:11]),
		.in_noise  ($signed(s_axis_tdata[58:27])),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.out_item  (sc_item)
	);

	ngcr_curve u_curve (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sc_valid),
		.in_ready    (sc_ready),
		.in_item     (sc_item),
		.out_valid   (wt_valid),
		.out_ready   (wt_ready),
		.out_weights (wt)
	);

	ngcr_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (wt_valid),
		.in_ready   (wt_ready),
		.in_weights (wt),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_chan   (chan)
	);

	assign m_axis_tdata = {chan[3], chan[2], chan[1], chan[0]};

	// a ready sink must never throttle the source
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// an empty output stage frees the whole chain
	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// blend weights add to full scale, one less when the start weight saturates
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		wt_valid |-> ((16'(wt.wa) + 16'(wt.wb) == WEIGHT_FULL)
			|| (16'(wt.wa) + 16'(wt.wb) == 16'(WEIGHT_MAX))))
		else $error("blend weights out of balance");

endmodule

// ----- tb/sv/color_ramp_checker.sv -----
`timescale 1ns / 1ps

module color_ramp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // curve_index[10:0], curve_value[26:11], noise_sum[58:27]
	input  logic        s_axis_tuser,  // command[0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,  // chan_red[15:0], chan_green[31:16], chan_blue[47:32], chan_alpha[63:48]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	import ngcr_pkg::*;

	typedef logic [NUM_CHAN-1:0][15:0] pixel_t;

	logic signed [31:0] cfg_amp    = AMPLITUDE_RST;
	logic               cfg_signed = SIGNED_MODE_RST;
	logic [31:0]        cfg_start  = COLOR_START_RST;
	logic [31:0]        cfg_end    = COLOR_END_RST;
	logic [15:0]        curve_mem [CURVE_ENTRIES];
	pixel_t             pixel_q [$];
	pixel_t             want;
	pixel_t             seen;
	logic [31:0]        reg_val;
	string              lane;
	int                 c;

	// scale, offset and clamp the noise, walk the gamma curve, then blend the two colors
	function automatic pixel_t shade_pixel(input logic signed [31:0] noise);
		logic signed [63:0] n64;
		logic signed [63:0] a64;
		logic signed [63:0] prod;
		logic signed [31:0] lvl32;
		int level, g0, g1, fade, half, wa, wb, sh, ca, cb, sum;
		pixel_t px;
		n64 = noise;
		a64 = cfg_amp;
		prod = n64 * a64;
		lvl32 = prod[47:16];
		if (!cfg_signed)
			lvl32 = lvl32 + LEVEL_OFFSET;
		if (lvl32 < 0)
			level = 0;
		else if (lvl32 > 32'sh7fff)
			level = 'h7fff;
		else
			level = lvl32;
		g0 = curve_mem[level >> 5];
		g1 = curve_mem[(level >> 5) + 1];
		fade = g0 + (((g1 - g0) * (level & 31)) >>> 5);
		half = fade >>> 1;
		wb = (half > 'h7fff) ? 'h7fff : half;
		wa = 'h8000 - half;
		if (wa > 'h7fff)
			wa = 'h7fff;
		for (int k = 0; k < NUM_CHAN; k++) begin
			sh = (k == 3) ? 24 : 16 - 8 * k;
			ca = (((cfg_start >> sh) & 255) * 257) >> 1;
			cb = (((cfg_end >> sh) & 255) * 257) >> 1;
			sum = ((ca * wa) >>> 16) + ((cb * wb) >>> 16);
			px[k] = {sum[14:0], 1'b0};
		end
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_amp    = AMPLITUDE_RST;
			cfg_signed = SIGNED_MODE_RST;
			cfg_start  = COLOR_START_RST;
			cfg_end    = COLOR_END_RST;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_SHADE)
					pixel_q.push_back(shade_pixel(s_axis_tdata[58:27]));
				else if (s_axis_tdata[10:0] < CURVE_ENTRIES)
					curve_mem[s_axis_tdata[10:0]] = s_axis_tdata[26:11];
			end

			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata;
				if (pixel_q.size() == 0) begin
					errors++;
					$display("%0t: pixel with none pending: expected nothing got %h",
						$time, seen);
				end else begin
					want = pixel_q.pop_front();
					for (c = 0; c < NUM_CHAN; c++) begin
						if (seen[c] !== want[c]) begin
							errors++;
							case (c)
								0: lane = "red";
								1: lane = "green";
								2: lane = "blue";
								default: lane = "alpha";
							endcase
							$display("%0t: %s expected %h got %h", $time, lane, want[c], seen[c]);
						end
					end
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_AMPLITUDE:   cfg_amp = pwdata;
						REG_SIGNED_MODE: cfg_signed = pwdata[0];
						REG_COLOR_START: cfg_start = pwdata;
						default:         cfg_end = pwdata;
					endcase
				end else begin
					case (paddr[3:2])
						REG_AMPLITUDE:   reg_val = cfg_amp;
						REG_SIGNED_MODE: reg_val = {31'b0, cfg_signed};
						REG_COLOR_START: reg_val = cfg_start;
						default:         reg_val = cfg_end;
					endcase
					if (prdata !== reg_val) begin
						errors++;
						$display("%0t: register %0d read expected %h got %h",
							$time, paddr[3:2], reg_val, prdata);
					end
				end
			end
		end
		pending = pixel_q.size();
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import ngcr_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int QUIET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 85;
	localparam int FILL_ITEMS   = 64;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;  // curve_index[10:0], curve_value[26:11], noise_sum[58:27]
	logic        s_axis_tuser;  // command[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;  // chan_red[15:0], chan_green[31:16], chan_blue[47:32], chan_alpha[63:48]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	// register values in force and curve entries loaded so far
	logic signed [31:0] cur_amp = AMPLITUDE_RST;
	logic               cur_sm  = SIGNED_MODE_RST;
	bit                 curve_written [CURVE_ENTRIES];

	always #5 clk = ~clk;

	noise_gamma_color_ramp_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	color_ramp_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.errors        (errors),
		.pending       (pending)
	);

	// output side: runs of full rate, coin-flip backpressure and solid stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = (stall_mode == 2) ? $urandom_range(1, 20) : $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable && pready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// first curve entry that a shade of this noise reads, with the registers in force
	function automatic int curve_pos(input logic signed [31:0] noise);
		logic signed [63:0] n64;
		logic signed [63:0] a64;
		logic signed [63:0] prod;
		logic signed [31:0] lvl;
		n64 = noise;
		a64 = cur_amp;
		prod = n64 * a64;
		lvl = prod[47:16];
		if (!cur_sm)
			lvl = lvl + LEVEL_OFFSET;
		if (lvl < 0)
			lvl = 0;
		else if (lvl > 32'sh7fff)
			lvl = 32'sh7fff;
		return int'(lvl) >> FRAC_W;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(input logic cmd, input logic [10:0] idx, input logic [15:0] value,
			input logic [31:0] noise);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {5'b0, noise, value, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic load_entry(input logic [10:0] idx, input logic [15:0] value);
		if (int'(idx) < CURVE_ENTRIES)
			curve_written[idx] = 1'b1;
		send_item(CMD_LOAD, idx, value, $urandom);
	endtask

	// loads whatever curve entries the shade reads that are still unwritten
	task automatic shade_item(input logic [31:0] noise);
		int pos;
		pos = curve_pos(noise);
		for (int e = pos; e <= pos + 1; e++) begin
			if (!curve_written[e])
				load_entry(CURVE_AW'(e), 16'($urandom_range(0, 65534)));
		end
		send_item(CMD_SHADE, 11'($urandom_range(0, 2047)), 16'($urandom), noise);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] reg_idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// registers change only with the pipeline empty
	task automatic set_regs(input logic [31:0] amp, input logic sm, input logic [31:0] c0,
			input logic [31:0] c1);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
		apb_xfer(1'b1, REG_AMPLITUDE, amp);
		apb_xfer(1'b1, REG_SIGNED_MODE, {31'b0, sm});
		apb_xfer(1'b1, REG_COLOR_START, c0);
		apb_xfer(1'b1, REG_COLOR_END, c1);
		apb_xfer(1'b0, REG_AMPLITUDE, 32'b0);
		apb_xfer(1'b0, REG_SIGNED_MODE, 32'b0);
		apb_xfer(1'b0, REG_COLOR_START, 32'b0);
		apb_xfer(1'b0, REG_COLOR_END, 32'b0);
		cur_amp = amp;
		cur_sm  = sm;
	endtask

	initial begin
		int r;
		int amp;
		logic [31:0] noise;
		logic [15:0] value;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = CMD_LOAD;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// low end of the curve up front; the rest is loaded when a shade first needs it
		for (int i = 0; i < FILL_ITEMS; i++) begin
			case (i)
				0: value = 16'd0;
				1: value = 16'd65534;
				default: value = 16'($urandom_range(0, 65534));
			endcase
			load_entry(CURVE_AW'(i), value);
		end

		// unity gain, no offset: level equals the noise sum, clamped to 0..0x7fff
		set_regs(32'sd65536, 1'b1, 32'h0000_0000, 32'hffff_ffff);
		load_entry(11'd1025, 16'hffff);  // out of range, dropped
		load_entry(11'd2047, 16'h1234);
		load_entry(11'd1024, 16'd65534);
		load_entry(11'd0, 16'd0);
		shade_item(32'd0);
		shade_item(32'd31);
		shade_item(32'd32);
		shade_item(32'h7fe0);
		shade_item(32'h7fff);
		shade_item(32'h8000);
		shade_item(32'hffff_ffff);
		shade_item(32'h7fff_ffff);
		shade_item(32'h8000_0000);
		// a load right before a shade that reads the same entry
		load_entry(11'd5, 16'd65534);
		shade_item(32'd176);

		// offset on: the offset add can wrap past the top of 32 bits
		set_regs(32'sd65536, 1'b0, 32'h80ff_00aa, 32'h7f00_ff55);
		shade_item(32'd0);
		shade_item(32'h7fff_d000);
		shade_item(32'hffff_c000);

		// product wrap at the amplitude extremes
		set_regs(32'h7fff_ffff, 1'b0, 32'hffff_ffff, 32'h0000_0000);
		shade_item(32'h7fff_ffff);
		shade_item(32'h8000_0000);
		set_regs(32'h8000_0000, 1'b0, 32'hffff_ffff, 32'h0000_0000);
		shade_item(32'h8000_0000);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_regs(AMPLITUDE_RST, 1'b0, COLOR_START_RST, COLOR_END_RST);
				1: set_regs(32'sd65536, 1'b1, 32'h0000_0000, 32'hffff_ffff);
				2: set_regs(32'h7fff_ffff, 1'b0, 32'hffff_ffff, 32'h0000_0000);
				3: set_regs(32'h8000_0000, 1'b1, $urandom, $urandom);
				4: set_regs(-32'sd65536, 1'b0, $urandom, $urandom);
				5: set_regs(32'd0, 1'b1, $urandom, $urandom);
				6: set_regs($urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
				default: begin
					amp = $urandom_range(1, 1 << 18);
					if ($urandom_range(0, 1))
						amp = -amp;
					set_regs(amp, 1'($urandom_range(0, 1)), $urandom, $urandom);
				end
			endcase
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// a few loads aim past the end of the curve
					load_entry((r < 4) ? 11'($urandom_range(CURVE_ENTRIES, 2047)) :
							11'($urandom_range(0, CURVE_ENTRIES - 1)),
						16'($urandom_range(0, 65534)));
				end else begin
					r = $urandom_range(0, 9);
					if (r < 2)
						noise = $urandom;
					else if (r == 2) begin
						case ($urandom_range(0, 3))
							0: noise = 32'h7fff_ffff;
							1: noise = 32'h8000_0000;
							2: noise = 32'h0000_0000;
							default: noise = 32'hffff_ffff;
						endcase
					end else
						noise = $urandom_range(0, 1 << 17) - (1 << 16);
					shade_item(noise);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
